### hw/rtl/mls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mls_pkg: shared types and defaults for the modular linear solver
// Holds the default operand width and the divider control bundle.
// ----------------------------------------------------------------------------
package mls_pkg;

  localparam int unsigned VALUE_BITS_DEF = 22;

  // Divider launch control: go starts a run, wide selects a 2W-bit dividend.
  typedef struct packed {
    logic go;
    logic wide;
  } div_ctl_t;

endpackage
`default_nettype wire

### hw/rtl/mls_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mls_divider: shared bit-serial restoring divider
// One quotient bit per cycle. Narrow runs take a W-bit dividend and
// wide runs a 2W-bit dividend. done pulses with results valid.
// ----------------------------------------------------------------------------
module mls_divider #(
  parameter int unsigned W = mls_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  mls_pkg::div_ctl_t ctl,
  input  logic [2*W-1:0]    dividend,
  input  logic [W-1:0]      divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);

  localparam int unsigned CW = $clog2(2 * W + 1);

  logic [2*W-1:0] dvd;
  logic [W-1:0]   dsr;
  logic [CW-1:0]  cnt;
  logic           run;
  logic [W:0]     trial;
  logic [W:0]     diff;
  logic           ge;

  assign trial = {remainder, dvd[2*W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.go) begin
        run       <= 1'b1;
        cnt       <= ctl.wide ? CW'(2 * W) : CW'(W);
        // narrow dividend sits in the top half so the same shift path works
        dvd       <= ctl.wide ? dividend : {dividend[W-1:0], {W{1'b0}}};
        dsr       <= divisor;
        remainder <= '0;
        quotient  <= '0;
      end else if (run) begin
        dvd       <= {dvd[2*W-2:0], 1'b0};
        remainder <= ge ? diff[W-1:0] : trial[W-1:0];
        quotient  <= {quotient[W-2:0], ge};
        cnt       <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/modular_linear_solver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_linear_solver_unit: solves k*j = r (mod n) by extended Euclid
// Sequencer around one shared serial divider and a single product register.
// ----------------------------------------------------------------------------
// Trivial inputs (r=0, j<=1, n=0) raise done in the cycle after start.
// Otherwise the setup divides run first, then each Euclid step does one
// product, a 2W-bit mod reduction and a W-bit divide, all through the
// serial divider at one bit per cycle. One item at a time: busy stays high
// until the beat is on solution. done is a one-cycle strobe and the receiver
// cannot stall. Synchronous reset returns the block to idle.
module modular_linear_solver_unit #(
  parameter int unsigned VALUE_BITS = mls_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] multiplier,
  input  logic [VALUE_BITS-1:0] modulus,
  input  logic [VALUE_BITS-1:0] residue,
  output logic                  done,
  output logic [VALUE_BITS-1:0] solution
);

  localparam int unsigned W = VALUE_BITS;
  localparam logic [W-1:0] ONE = W'(1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RED  = 8'b0000_0010,
    S_DIV0 = 8'b0000_0100,
    S_DIV1 = 8'b0000_1000,
    S_DIVL = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_MOD  = 8'b0100_0000
  } state_t;

  state_t            state;
  logic [W-1:0]      j_r, n_r, r_r;
  logic [W-1:0]      num, den, q, q_prev, p, p_prev;
  logic [2*W-1:0]    prod;
  logic              final_step;
  logic              div_go, div_wide;
  mls_pkg::div_ctl_t div_ctl;
  logic [2*W-1:0]    div_dvd;
  logic [W-1:0]      div_dsr;
  logic              div_done;
  logic [W-1:0]      div_quo, div_rem;
  logic [W-1:0]      mod_diff, mod_res;

  assign busy         = (state != S_IDLE);
  assign div_ctl.go   = div_go;
  assign div_ctl.wide = div_wide;

  always_comb begin
    unique case (state)
      S_RED: begin
        div_dvd = {{W{1'b0}}, r_r};
        div_dsr = n_r;
      end
      S_DIV0: begin
        div_dvd = {{W{1'b0}}, n_r};
        div_dsr = j_r;
      end
      S_MOD: begin
        div_dvd = prod;
        div_dsr = n_r;
      end
      default: begin
        div_dvd = {{W{1'b0}}, num};
        div_dsr = den;
      end
    endcase
  end

  // (p_prev - p*q_prev) mod n; both terms already below n, so W-bit wrap is exact
  assign mod_diff = p_prev - div_rem;
  assign mod_res  = (p_prev < div_rem) ? (mod_diff + n_r) : mod_diff;

  mls_divider #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      div_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            j_r <= multiplier;
            n_r <= modulus;
            r_r <= residue;
            priority if (residue == '0) begin
              solution <= '0;
              done     <= 1'b1;
            end else if (multiplier == ONE) begin
              solution <= residue;
              done     <= 1'b1;
            end else if (multiplier == '0 || modulus == '0) begin
              solution <= '0;
              done     <= 1'b1;
            end else begin
              state    <= S_RED;
              div_go   <= 1'b1;
              div_wide <= 1'b0;
            end
          end
        end
        S_RED: begin
          if (div_done) begin
            p        <= div_rem;       // r mod n
            state    <= S_DIV0;
            div_go   <= 1'b1;
            div_wide <= 1'b0;
          end
        end
        S_DIV0: begin
          if (div_done) begin
            p_prev <= '0;
            q_prev <= div_quo;
            num    <= j_r;
            den    <= div_rem;
            priority if (div_rem == '0) begin
              solution <= '0;
              done     <= 1'b1;
              state    <= S_IDLE;
            end else if (div_rem == ONE) begin
              final_step <= 1'b1;
              state      <= S_MUL;
            end else begin
              state    <= S_DIV1;
              div_go   <= 1'b1;
              div_wide <= 1'b0;
            end
          end
        end
        S_DIV1, S_DIVL: begin
          if (div_done) begin
            if (state == S_DIVL) begin
              q_prev <= q;
            end
            q          <= div_quo;
            num        <= den;
            den        <= div_rem;
            final_step <= (div_rem == '0);
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          prod     <= (2*W)'(p) * (2*W)'(q_prev);
          state    <= S_MOD;
          div_go   <= 1'b1;
          div_wide <= 1'b1;
        end
        S_MOD: begin
          if (div_done) begin
            if (final_step) begin
              solution <= mod_res;
              done     <= 1'b1;
              state    <= S_IDLE;
            end else begin
              p_prev   <= p;
              p        <= mod_res;
              state    <= S_DIVL;
              div_go   <= 1'b1;
              div_wide <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // divider is never launched against a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_go |-> (div_dsr != '0))
    else $error("divider launched with zero divisor");

  // a result beat only appears with the unit back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while busy");

  // partial solution stays reduced when the update completes
  a_p_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD && div_done) |-> (p_prev < n_r && div_rem < n_r))
    else $error("partial solution not reduced modulo n");

endmodule
`default_nettype wire
